// File: hw/rtl/video_source_health_monitor_assert.svh
// Assertion macros shared by the monitor RTL.
// Each macro takes a label, a condition and a consequence, and is sampled
// on the rising clock edge with reset masking the check.
`ifndef VIDEO_SOURCE_HEALTH_MONITOR_ASSERT_SVH
`define VIDEO_SOURCE_HEALTH_MONITOR_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define VSHM_ASSERT_SAME(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("vshm same-cycle assertion failed");

// The consequence must hold in the cycle after the condition.
`define VSHM_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("vshm next-cycle assertion failed");

`endif

// File: hw/rtl/vshm_pkg.sv
package vshm_pkg;

   // Field widths fixed by the interface.
   localparam int TIME_WIDTH = 48;
   localparam int CFG_WIDTH  = 32;
   localparam int OUT_WIDTH  = 32;
   localparam int FPS_WIDTH  = 32;
   localparam int CSR_IDX_WIDTH = 2;

   // Defaults for the top-level parameters.
   localparam int COUNT_WIDTH_DEF   = 32;
   localparam int FPS_FRAC_BITS_DEF = 8;

   // Register reset values.
   localparam logic [CFG_WIDTH-1:0] STALE_LIMIT_RESET = 32'd500000;
   localparam logic [CFG_WIDTH-1:0] RATE_WINDOW_RESET = 32'd1000000;
   localparam logic [CFG_WIDTH-1:0] TICKS_PER_SEC_RESET = 32'd1000000;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_STALE_LIMIT   = 2'd0,
      REG_RATE_WINDOW   = 2'd1,
      REG_TICKS_PER_SEC = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_ARRIVAL = 1'b0,
      FUNC_UPDATE  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      SIG_WAITING = 2'd0,
      SIG_LIVE    = 2'd1,
      SIG_STALE   = 2'd2
   } sig_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_ELAPSED,
      ST_MUL,
      ST_DIV,
      ST_AGE,
      ST_OUT
   } fsm_type;

endpackage

// File: hw/rtl/video_source_health_monitor.sv
// Channel  Direction  Handshake           Contents
// req_     in         valid / stall       event kind, tick time, overwrite and consume flags
// rsp_     out        valid / stall       four counters, signal state, age, capture and reported fps
// csr_     in         valid / ready       register index and 32-bit write data
//
// An update passes through ST_AGE and a restarting arrival through ST_GAP before its result
// is offered in ST_OUT; an arrival with zero elapsed time also passes ST_ELAPSED. A measuring
// arrival then runs a shift-add multiply in ST_MUL and a restoring divide in ST_DIV, which
// stops once the quotient saturates or every dividend bit has been used.
// Reset is synchronous and active high; it loads the register defaults and clears the architectural state.
// req_stall is high from acceptance until the result is taken, and rsp_stall holds it.
`include "video_source_health_monitor_assert.svh"

module video_source_health_monitor #(
   parameter int COUNT_WIDTH   = vshm_pkg::COUNT_WIDTH_DEF,
   parameter int FPS_FRAC_BITS = vshm_pkg::FPS_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [vshm_pkg::TIME_WIDTH-1:0]       req_time_ticks,
   input  logic                                  req_overwrites_pending,
   input  logic                                  req_consumed_frame,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [vshm_pkg::OUT_WIDTH-1:0]        rsp_received_count,
   output logic [vshm_pkg::OUT_WIDTH-1:0]        rsp_overwritten_count,
   output logic [vshm_pkg::OUT_WIDTH-1:0]        rsp_consumed_count,
   output logic [vshm_pkg::OUT_WIDTH-1:0]        rsp_repeated_count,
   output logic [1:0]                            rsp_signal_state,
   output logic [vshm_pkg::TIME_WIDTH-1:0]       rsp_age_ticks,
   output logic [vshm_pkg::FPS_WIDTH-1:0]        rsp_capture_fps_q8,
   output logic [vshm_pkg::FPS_WIDTH-1:0]        rsp_reported_fps_q8,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vshm_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [vshm_pkg::CFG_WIDTH-1:0]        csr_data
);
   import vshm_pkg::*;

   // The product intervals * ticks_per_second, and the dividend scaled by the
   // fraction bits. The remainder stays below the elapsed time, so it needs one
   // bit more than a timestamp once shifted.
   localparam int PROD_WIDTH = COUNT_WIDTH + CFG_WIDTH;
   localparam int DVD_WIDTH  = PROD_WIDTH + FPS_FRAC_BITS;
   localparam int REM_WIDTH  = TIME_WIDTH + 1;
   localparam int DCNT_WIDTH = $clog2(DVD_WIDTH + 1);

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      if (c == '1) begin
         return c;
      end
      return c + COUNT_WIDTH'(1);
   endfunction

   // Counters are reported in 32 bits and stop at all ones if they are wider.
   function automatic logic [OUT_WIDTH-1:0] out_sat(input logic [COUNT_WIDTH-1:0] c);
      if ((COUNT_WIDTH > OUT_WIDTH) && ((c >> OUT_WIDTH) != '0)) begin
         return '1;
      end
      return OUT_WIDTH'(c);
   endfunction

   // Control and architectural state.
   fsm_type                  state_ff, state_in;
   logic [CFG_WIDTH-1:0]     stale_limit_ff;
   logic [CFG_WIDTH-1:0]     rate_window_ff;
   logic [CFG_WIDTH-1:0]     ticks_per_sec_ff;
   logic [COUNT_WIDTH-1:0]   received_ff;
   logic [COUNT_WIDTH-1:0]   overwritten_ff;
   logic [COUNT_WIDTH-1:0]   consumed_ff;
   logic [COUNT_WIDTH-1:0]   repeated_ff;
   logic [COUNT_WIDTH-1:0]   intervals_ff;
   logic [TIME_WIDTH-1:0]    last_arrival_ff;
   logic [TIME_WIDTH-1:0]    window_start_ff;
   logic [TIME_WIDTH-1:0]    consumed_arrival_ff;
   logic [FPS_WIDTH-1:0]     capture_rate_ff;
   sig_type                  health_signal_ff;
   logic [TIME_WIDTH-1:0]    health_age_ff;
   logic [FPS_WIDTH-1:0]     health_fps_ff;

   // Working registers for the item in flight.
   logic [TIME_WIDTH-1:0]    item_time_ff;
   logic                     item_overwrite_ff;
   logic                     item_consumed_ff;
   logic [TIME_WIDTH-1:0]    elapsed_ff;
   logic [PROD_WIDTH-1:0]    mcand_ff;
   logic [CFG_WIDTH-1:0]     mplier_ff;
   logic [PROD_WIDTH-1:0]    prod_ff;
   logic [DVD_WIDTH-1:0]     dvd_ff;
   logic [REM_WIDTH-1:0]     rem_ff;
   logic [FPS_WIDTH-1:0]     quot_ff;
   logic [DCNT_WIDTH-1:0]    div_cnt_ff;

   logic                     req_accept;

   // Shared time subtractor: floor(item time - operand), compared against a limit.
   logic [TIME_WIDTH-1:0]    sub_operand;
   logic [TIME_WIDTH-1:0]    diff;
   logic [CFG_WIDTH-1:0]     diff_limit;
   logic                     diff_at_limit;

   // Consumer update values.
   logic [COUNT_WIDTH-1:0]   consumed_in;
   logic [TIME_WIDTH-1:0]    consumed_arrival_in;

   // Arrival decisions.
   logic                     restart;

   // Divider step.
   logic [REM_WIDTH-1:0]     rem_shift;
   logic                     q_bit;
   logic [REM_WIDTH-1:0]     rem_next;
   logic [FPS_WIDTH-1:0]     quot_next;
   logic                     div_sat;
   logic                     div_last;

   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Update: a consumed frame moves the consumed arrival to the last arrival.
   assign consumed_in         = item_consumed_ff ? sat_inc(consumed_ff) : consumed_ff;
   assign consumed_arrival_in = item_consumed_ff ? last_arrival_ff : consumed_arrival_ff;

   always_comb begin
      unique case (state_ff)
         ST_GAP:     sub_operand = last_arrival_ff;
         ST_ELAPSED: sub_operand = window_start_ff;
         default:    sub_operand = consumed_arrival_in;
      endcase
   end

   assign diff          = (item_time_ff >= sub_operand) ? item_time_ff - sub_operand : '0;
   assign diff_limit    = (state_ff == ST_ELAPSED) ? rate_window_ff : stale_limit_ff;
   assign diff_at_limit = diff >= TIME_WIDTH'(diff_limit);

   // The first frame, or any frame after a stale gap, restarts the window.
   assign restart = (received_ff == '0) || diff_at_limit;

   // One restoring division step, quotient bits most significant first.
   assign rem_shift = {rem_ff[REM_WIDTH-2:0], dvd_ff[DVD_WIDTH-1]};
   assign q_bit     = rem_shift >= REM_WIDTH'(elapsed_ff);
   assign rem_next  = q_bit ? rem_shift - REM_WIDTH'(elapsed_ff) : rem_shift;
   assign quot_next = {quot_ff[FPS_WIDTH-2:0], q_bit};
   // With the top quotient bit already set, the next step would exceed 32 bits.
   assign div_sat   = quot_ff[FPS_WIDTH-1];
   assign div_last  = div_cnt_ff == DCNT_WIDTH'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (func_type'(req_func) == FUNC_UPDATE) ? ST_AGE : ST_GAP;
            end
         end
         ST_GAP: begin
            state_in = restart ? ST_OUT : ST_ELAPSED;
         end
         ST_ELAPSED: begin
            state_in = (diff == '0) ? ST_OUT : ST_MUL;
         end
         ST_MUL: begin
            if (mplier_ff == '0) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sat || div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_AGE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_OUT:  rsp_valid = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // Registers and architectural state; reset loads the register defaults and clears the rest.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         stale_limit_ff      <= STALE_LIMIT_RESET;
         rate_window_ff      <= RATE_WINDOW_RESET;
         ticks_per_sec_ff    <= TICKS_PER_SEC_RESET;
         received_ff         <= '0;
         overwritten_ff      <= '0;
         consumed_ff         <= '0;
         repeated_ff         <= '0;
         intervals_ff        <= '0;
         last_arrival_ff     <= '0;
         window_start_ff     <= '0;
         consumed_arrival_ff <= '0;
         capture_rate_ff     <= '0;
         health_signal_ff    <= SIG_WAITING;
         health_age_ff       <= '0;
         health_fps_ff       <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               REG_STALE_LIMIT:   stale_limit_ff   <= csr_data;
               REG_RATE_WINDOW:   rate_window_ff   <= csr_data;
               REG_TICKS_PER_SEC: ticks_per_sec_ff <= csr_data;
               default: begin
               end
            endcase
         end

         unique case (state_ff)
            ST_GAP: begin
               received_ff     <= sat_inc(received_ff);
               if (item_overwrite_ff) begin
                  overwritten_ff <= sat_inc(overwritten_ff);
               end
               last_arrival_ff <= item_time_ff;
               if (restart) begin
                  window_start_ff <= item_time_ff;
                  intervals_ff    <= '0;
                  capture_rate_ff <= '0;
               end else begin
                  intervals_ff    <= sat_inc(intervals_ff);
               end
            end
            ST_ELAPSED: begin
               // The interval count is copied into the multiplier at this same edge,
               // so the window can roll over now.
               if (diff_at_limit) begin
                  window_start_ff <= item_time_ff;
                  intervals_ff    <= '0;
               end
            end
            ST_DIV: begin
               if (div_sat) begin
                  capture_rate_ff <= '1;
               end else if (div_last) begin
                  capture_rate_ff <= quot_next;
               end
            end
            ST_AGE: begin
               consumed_ff         <= consumed_in;
               consumed_arrival_ff <= consumed_arrival_in;
               if (!item_consumed_ff && (consumed_ff != '0)) begin
                  repeated_ff <= sat_inc(repeated_ff);
               end
               if (consumed_in == '0) begin
                  health_signal_ff <= SIG_WAITING;
                  health_age_ff    <= '0;
                  health_fps_ff    <= '0;
               end else if (diff_at_limit) begin
                  health_signal_ff <= SIG_STALE;
                  health_age_ff    <= diff;
                  health_fps_ff    <= '0;
               end else begin
                  health_signal_ff <= SIG_LIVE;
                  health_age_ff    <= diff;
                  health_fps_ff    <= capture_rate_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Item and arithmetic working registers; every use is loaded first.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_time_ff      <= req_time_ticks;
               item_overwrite_ff <= req_overwrites_pending;
               item_consumed_ff  <= req_consumed_frame;
            end
         end
         ST_ELAPSED: begin
            elapsed_ff <= diff;
            mcand_ff   <= PROD_WIDTH'(intervals_ff);
            mplier_ff  <= ticks_per_sec_ff;
            prod_ff    <= '0;
         end
         ST_MUL: begin
            if (mplier_ff == '0) begin
               dvd_ff     <= DVD_WIDTH'(prod_ff) << FPS_FRAC_BITS;
               rem_ff     <= '0;
               quot_ff    <= '0;
               div_cnt_ff <= DCNT_WIDTH'(DVD_WIDTH);
            end else begin
               if (mplier_ff[0]) begin
                  prod_ff <= prod_ff + mcand_ff;
               end
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
            end
         end
         ST_DIV: begin
            dvd_ff     <= dvd_ff << 1;
            rem_ff     <= rem_next;
            quot_ff    <= quot_next;
            div_cnt_ff <= div_cnt_ff - DCNT_WIDTH'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp_received_count    = out_sat(received_ff);
   assign rsp_overwritten_count = out_sat(overwritten_ff);
   assign rsp_consumed_count    = out_sat(consumed_ff);
   assign rsp_repeated_count    = out_sat(repeated_ff);
   assign rsp_signal_state      = health_signal_ff;
   assign rsp_age_ticks         = health_age_ff;
   assign rsp_capture_fps_q8    = capture_rate_ff;
   assign rsp_reported_fps_q8   = health_fps_ff;

   // A result is only offered while the input side is held off.
   `VSHM_ASSERT_SAME(a_one_item_in_flight, rsp_valid, req_stall)
   // An accepted item is worked on before any result appears.
   `VSHM_ASSERT_NEXT(a_accept_starts_work, req_accept, req_stall && !rsp_valid)
   // Fps is reported only while the signal is live.
   `VSHM_ASSERT_SAME(a_fps_only_live, health_signal_ff != SIG_LIVE, health_fps_ff == '0)
   // A waiting signal has no age, and no consumed frame behind it.
   `VSHM_ASSERT_SAME(a_waiting_is_empty, health_signal_ff == SIG_WAITING, health_age_ff == '0)

endmodule

// File: verif/video_source_health_monitor_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the video source health monitor. Items go in on the
// req_ channel and results come back on the rsp_ channel. Every accepted item is
// run through a local copy of the monitor's behavior, and the result it predicts, or
// the row's own expected result, is queued. Each result the block hands back is checked
// against the oldest entry in that queue.
module video_source_health_monitor_test;
   import vshm_pkg::*;

   localparam int FRAC_BITS = FPS_FRAC_BITS_DEF;

   // The watchdog limit lies far above what a slow arrival takes, so only a hung
   // block trips it.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 200;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int DIRECTED_COUNT = 22;

   // Index 3 names no register. A write to it must leave all three registers alone.
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REGISTER_ORDER [4] = '{
      REG_STALE_LIMIT, REG_RATE_WINDOW, REG_TICKS_PER_SEC, REG_UNUSED
   };

   typedef struct packed {
      logic [OUT_WIDTH-1:0]  received;
      logic [OUT_WIDTH-1:0]  overwritten;
      logic [OUT_WIDTH-1:0]  consumed;
      logic [OUT_WIDTH-1:0]  repeated;
      sig_type               sig_state;
      logic [TIME_WIDTH-1:0] age;
      logic [FPS_WIDTH-1:0]  capture_fps;
      logic [FPS_WIDTH-1:0]  reported_fps;
   } health_report_t;

   // One row of the directed table. Where typed is set, the row carries its own
   // expected result. Otherwise the predictor supplies the expected result.
   typedef struct packed {
      func_type              func;
      logic [TIME_WIDTH-1:0] when;
      logic                  overwrite;
      logic                  consume;
      logic                  typed;
      health_report_t        report;
   } stimulus_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   func_type                 req_func = FUNC_ARRIVAL;
   logic [TIME_WIDTH-1:0]    req_time_ticks = '0;
   logic                     req_overwrites_pending = 1'b0;
   logic                     req_consumed_frame = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [OUT_WIDTH-1:0]     rsp_received_count;
   logic [OUT_WIDTH-1:0]     rsp_overwritten_count;
   logic [OUT_WIDTH-1:0]     rsp_consumed_count;
   logic [OUT_WIDTH-1:0]     rsp_repeated_count;
   logic [1:0]               rsp_signal_state;
   logic [TIME_WIDTH-1:0]    rsp_age_ticks;
   logic [FPS_WIDTH-1:0]     rsp_capture_fps_q8;
   logic [FPS_WIDTH-1:0]     rsp_reported_fps_q8;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = REG_STALE_LIMIT;
   logic [CFG_WIDTH-1:0]     csr_data = '0;

   // These travel with the item on the request side, so the monitor knows whether
   // the current item brings its own expected result.
   logic           row_typed = 1'b0;
   health_report_t row_expect = '0;

   // While calm is set, neither side inserts idle cycles.
   logic calm = 1'b0;

   health_report_t pending_reports [$];
   int error_count = 0;
   int idle_cycles = 0;

   // The predictor keeps its own copy of the registers and the health state.
   logic [CFG_WIDTH-1:0]  stale_limit;
   logic [CFG_WIDTH-1:0]  window_length;
   logic [CFG_WIDTH-1:0]  tick_rate;
   logic [OUT_WIDTH-1:0]  frames_received;
   logic [OUT_WIDTH-1:0]  frames_overwritten;
   logic [OUT_WIDTH-1:0]  frames_consumed;
   logic [OUT_WIDTH-1:0]  frames_repeated;
   logic [OUT_WIDTH-1:0]  window_count;
   logic [FPS_WIDTH-1:0]  measured_rate;
   logic [TIME_WIDTH-1:0] latest_arrival;
   logic [TIME_WIDTH-1:0] window_origin;
   logic [TIME_WIDTH-1:0] consumed_stamp;
   sig_type               shown_state;
   logic [TIME_WIDTH-1:0] shown_age;
   logic [FPS_WIDTH-1:0]  shown_fps;

   // The directed table runs at the register defaults. It covers the first frame,
   // a zero elapsed time, a gap of exactly the stale limit and a larger one, a window
   // that fills up, a time that steps backward, and the time field at both ends.
   stimulus_row_t directed_rows [DIRECTED_COUNT] = '{
      '{FUNC_UPDATE,  48'd0,       1'b1, 1'b0, 1'b1,
        '{32'd0, 32'd0, 32'd0, 32'd0, SIG_WAITING, 48'd0, 32'd0, 32'd0}},
      '{FUNC_ARRIVAL, 48'd1000,    1'b0, 1'b1, 1'b1,
        '{32'd1, 32'd0, 32'd0, 32'd0, SIG_WAITING, 48'd0, 32'd0, 32'd0}},
      '{FUNC_ARRIVAL, 48'd1000,    1'b1, 1'b0, 1'b1,
        '{32'd2, 32'd1, 32'd0, 32'd0, SIG_WAITING, 48'd0, 32'd0, 32'd0}},
      '{FUNC_ARRIVAL, 48'd11000,   1'b0, 1'b0, 1'b0, '0},
      '{FUNC_UPDATE,  48'd12000,   1'b0, 1'b1, 1'b0, '0},
      '{FUNC_UPDATE,  48'd13000,   1'b1, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd21000,   1'b1, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd1021000, 1'b0, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd1521000, 1'b0, 1'b1, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd1520999, 1'b0, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd1600000, 1'b1, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd2520999, 1'b0, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd2900000, 1'b0, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd3300000, 1'b0, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd3700000, 1'b0, 1'b0, 1'b0, '0},
      '{FUNC_UPDATE,  48'd3700500, 1'b0, 1'b1, 1'b0, '0},
      '{FUNC_UPDATE,  48'd4300000, 1'b0, 1'b0, 1'b0, '0},
      '{FUNC_UPDATE,  48'd3000000, 1'b1, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, '0},
      '{FUNC_UPDATE,  48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, '0},
      '{FUNC_UPDATE,  48'd0,       1'b0, 1'b0, 1'b0, '0},
      '{FUNC_ARRIVAL, 48'd0,       1'b0, 1'b1, 1'b0, '0}
   };

   video_source_health_monitor DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_time_ticks         (req_time_ticks),
      .req_overwrites_pending (req_overwrites_pending),
      .req_consumed_frame     (req_consumed_frame),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_received_count     (rsp_received_count),
      .rsp_overwritten_count  (rsp_overwritten_count),
      .rsp_consumed_count     (rsp_consumed_count),
      .rsp_repeated_count     (rsp_repeated_count),
      .rsp_signal_state       (rsp_signal_state),
      .rsp_age_ticks          (rsp_age_ticks),
      .rsp_capture_fps_q8     (rsp_capture_fps_q8),
      .rsp_reported_fps_q8    (rsp_reported_fps_q8),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Counters stop at all ones.
   function automatic logic [OUT_WIDTH-1:0] bump(input logic [OUT_WIDTH-1:0] count);
      return (count == '1) ? count : count + 1'b1;
   endfunction

   // A difference that would go negative reads as zero.
   function automatic logic [TIME_WIDTH-1:0] span_floor(input logic [TIME_WIDTH-1:0] later,
                                                        input logic [TIME_WIDTH-1:0] earlier);
      return (later >= earlier) ? later - earlier : '0;
   endfunction

   // The rate is intervals * tick rate / elapsed with FRAC_BITS fraction bits. It is
   // truncated, and it saturates at all ones. The span must be nonzero.
   function automatic logic [FPS_WIDTH-1:0] scaled_rate(input logic [OUT_WIDTH-1:0] intervals,
                                                        input logic [CFG_WIDTH-1:0] rate,
                                                        input logic [TIME_WIDTH-1:0] span);
      logic [127:0] numerator;
      logic [127:0] quotient;
      numerator = (128'(intervals) * 128'(rate)) << FRAC_BITS;
      quotient = numerator / 128'(span);
      return (quotient > 128'hFFFF_FFFF) ? '1 : quotient[FPS_WIDTH-1:0];
   endfunction

   // This steps the predictor by one item and returns the result it expects.
   function automatic health_report_t track_health(input func_type func,
                                                   input logic [TIME_WIDTH-1:0] stamp,
                                                   input logic overwrite,
                                                   input logic consume);
      health_report_t report;
      logic restart;
      logic [TIME_WIDTH-1:0] elapsed;
      if (func == FUNC_ARRIVAL) begin
         // The first frame, or a frame after a stale gap, opens a new window.
         restart = (frames_received == '0) ||
                   (span_floor(stamp, latest_arrival) >= TIME_WIDTH'(stale_limit));
         frames_received = bump(frames_received);
         if (overwrite) begin
            frames_overwritten = bump(frames_overwritten);
         end
         latest_arrival = stamp;
         if (restart) begin
            window_origin = stamp;
            window_count = '0;
            measured_rate = '0;
         end else begin
            window_count = bump(window_count);
            elapsed = span_floor(stamp, window_origin);
            if (elapsed != '0) begin
               measured_rate = scaled_rate(window_count, tick_rate, elapsed);
            end
            if (elapsed >= TIME_WIDTH'(window_length)) begin
               window_origin = stamp;
               window_count = '0;
            end
         end
      end else begin
         if (consume) begin
            frames_consumed = bump(frames_consumed);
            consumed_stamp = latest_arrival;
         end else if (frames_consumed != '0) begin
            frames_repeated = bump(frames_repeated);
         end
         if (frames_consumed == '0) begin
            shown_state = SIG_WAITING;
            shown_age = '0;
            shown_fps = '0;
         end else begin
            shown_age = span_floor(stamp, consumed_stamp);
            shown_state = (shown_age >= TIME_WIDTH'(stale_limit)) ? SIG_STALE : SIG_LIVE;
            shown_fps = (shown_state == SIG_LIVE) ? measured_rate : '0;
         end
      end
      report.received = frames_received;
      report.overwritten = frames_overwritten;
      report.consumed = frames_consumed;
      report.repeated = frames_repeated;
      report.sig_state = shown_state;
      report.age = shown_age;
      report.capture_fps = measured_rate;
      report.reported_fps = shown_fps;
      return report;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   // All handshakes are sampled here at the rising edge. The result is checked
   // before the prediction for a new item is queued, so an item and a result that
   // meet at the same edge are handled in the right order. Register writes update
   // the predictor's copy at the same edge at which the block takes them.
   always @(posedge clock) begin
      health_report_t want;
      health_report_t predicted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("result item arrived with no request outstanding");
               error_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("received_count", want.received, rsp_received_count);
               check_field("overwritten_count", want.overwritten, rsp_overwritten_count);
               check_field("consumed_count", want.consumed, rsp_consumed_count);
               check_field("repeated_count", want.repeated, rsp_repeated_count);
               check_field("signal_state", want.sig_state, rsp_signal_state);
               check_field("age_ticks", want.age, rsp_age_ticks);
               check_field("capture_fps_q8", want.capture_fps, rsp_capture_fps_q8);
               check_field("reported_fps_q8", want.reported_fps, rsp_reported_fps_q8);
            end
         end
         if (req_valid && !req_stall) begin
            predicted = track_health(req_func, req_time_ticks, req_overwrites_pending,
                                     req_consumed_frame);
            pending_reports.push_back(row_typed ? row_expect : predicted);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_STALE_LIMIT: begin
                  stale_limit = csr_data;
               end
               REG_RATE_WINDOW: begin
                  window_length = csr_data;
               end
               REG_TICKS_PER_SEC: begin
                  tick_rate = csr_data;
               end
               default: begin
               end
            endcase
         end
      end else begin
         stale_limit = STALE_LIMIT_RESET;
         window_length = RATE_WINDOW_RESET;
         tick_rate = TICKS_PER_SEC_RESET;
         frames_received = '0;
         frames_overwritten = '0;
         frames_consumed = '0;
         frames_repeated = '0;
         window_count = '0;
         measured_rate = '0;
         latest_arrival = '0;
         window_origin = '0;
         consumed_stamp = '0;
         shown_state = SIG_WAITING;
         shown_age = '0;
         shown_fps = '0;
      end
   end

   // The result side stalls at random, with a chance of 15 in 100, except while calm.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
   end

   // The watchdog ends the run if no handshake of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("no handshake completed in %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // This presents one item and returns at the edge where it is taken. Valid stays
   // high on return, so a following item can go out without a gap. An idle gap, if
   // one is rolled, comes before the item is presented.
   task automatic offer_item(input func_type func, input logic [TIME_WIDTH-1:0] stamp,
                             input logic overwrite, input logic consume,
                             input logic typed, input health_report_t report);
      int gap_cycles;
      if (!calm && $urandom_range(0, 99) < 15) begin
         gap_cycles = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_time_ticks <= stamp;
      req_overwrites_pending <= overwrite;
      req_consumed_frame <= consume;
      row_typed <= typed;
      row_expect <= report;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // This drops valid after the last item and waits until every expected result
   // has come back. The block is then idle and can be reconfigured. Each item
   // causes exactly one result, so no extra settling time is needed.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // This writes the three registers in order and then the unused index with
   // random data. Valid stays high from one write to the next.
   task automatic program_registers(input logic [CFG_WIDTH-1:0] stale,
                                    input logic [CFG_WIDTH-1:0] span,
                                    input logic [CFG_WIDTH-1:0] rate);
      logic [CFG_WIDTH-1:0] values [4];
      values = '{stale, span, rate, $urandom};
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= REGISTER_ORDER[i];
         csr_data <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int roll;
      logic [CFG_WIDTH-1:0] stale_cfg;
      logic [CFG_WIDTH-1:0] span_cfg;
      logic [CFG_WIDTH-1:0] rate_cfg;
      logic [CFG_WIDTH-1:0] base;
      logic [CFG_WIDTH-1:0] period;
      logic [TIME_WIDTH-1:0] clock_now;
      logic [TIME_WIDTH-1:0] stamp;
      func_type func;
      logic overwrite;
      logic consume;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].func, directed_rows[i].when, directed_rows[i].overwrite,
                    directed_rows[i].consume, directed_rows[i].typed, directed_rows[i].report);
      end
      settle();

      // Each random phase uses its own register setting. The first four are fixed:
      // the defaults, all ones, all at one, and all at zero. Zero registers mean a
      // zero rate, a window that restarts after every interval, and an arrival that
      // always restarts. The rest are random. One phase runs with no idling at all.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               stale_cfg = STALE_LIMIT_RESET;
               span_cfg = RATE_WINDOW_RESET;
               rate_cfg = TICKS_PER_SEC_RESET;
            end
            1: begin
               stale_cfg = '1;
               span_cfg = '1;
               rate_cfg = '1;
            end
            2: begin
               stale_cfg = 32'd1;
               span_cfg = 32'd1;
               rate_cfg = 32'd1;
            end
            3: begin
               stale_cfg = '0;
               span_cfg = '0;
               rate_cfg = '0;
            end
            default: begin
               stale_cfg = $urandom_range(1000, 2000000);
               span_cfg = $urandom_range(1, 4000000);
               rate_cfg = $urandom;
            end
         endcase
         program_registers(stale_cfg, span_cfg, rate_cfg);
         calm <= (phase == 4);

         // Frames mostly arrive well inside the stale limit, so that windows fill
         // and the rate gets measured. Some phases use very short periods, which
         // drive the rate into saturation when the tick rate is large.
         base = (stale_cfg == '0) ? 32'd5000 : stale_cfg;
         period = base / $urandom_range(3, 30);
         if (phase == 1 || $urandom_range(0, 3) == 0) begin
            period = $urandom_range(1, 200);
         end
         if (period == '0) begin
            period = 32'd1;
         end
         clock_now = (phase == 5) ? 48'hFFFF_FFFF_FFFF - 48'd100000 : TIME_WIDTH'($urandom);

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               // This is noise: a time anywhere in the full range.
               clock_now = TIME_WIDTH'({$urandom, $urandom});
               stamp = clock_now;
            end else if (roll < 6) begin
               // The time steps backward, which the block must floor at zero.
               stamp = clock_now - TIME_WIDTH'($urandom_range(1, period));
               if (stamp > clock_now) begin
                  stamp = '0;
               end
            end else if (roll < 10) begin
               // The gap is at or beyond the stale limit.
               clock_now = clock_now + TIME_WIDTH'(stale_cfg) +
                           TIME_WIDTH'($urandom_range(0, period));
               stamp = clock_now;
            end else if (roll < 15) begin
               stamp = clock_now;
            end else begin
               clock_now = clock_now + TIME_WIDTH'($urandom_range(period / 2,
                                                                  period + period / 2));
               stamp = clock_now;
            end
            func = ($urandom_range(0, 99) < 55) ? FUNC_ARRIVAL : FUNC_UPDATE;
            overwrite = ($urandom_range(0, 99) < 30);
            consume = ($urandom_range(0, 99) < 60);
            offer_item(func, stamp, overwrite, consume, 1'b0, '0);
         end
         settle();
         calm <= 1'b0;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
